// ===== rtl/core/jicc_pkg.sv =====
// shared types, constants and helpers of the jpeg icc chunk scanner
// depends on nothing; imported by every module of the scanner
`default_nettype none

package jicc_pkg;

    localparam int DATA_W     = 8;
    localparam int LEN_W      = 16;
    localparam int OFFSET_W   = 16;
    localparam int CHUNK_W    = 8;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int MAP_DEPTH  = 256;
    localparam int GROUP_SIZE = 16;
    localparam int MAP_GROUPS = MAP_DEPTH / GROUP_SIZE;
    localparam int FIFO_DEPTH = 4;
    localparam int TDATA_USED = CHUNK_W + OFFSET_W + DATA_W + CHUNK_W + STATUS_W;
    localparam int TDATA_W    = ((TDATA_USED + 7) / 8) * 8;
    localparam int TDATA_PAD  = TDATA_W - TDATA_USED;

    localparam logic [DATA_W-1:0] MARK_PREFIX = 8'hFF;
    localparam logic [DATA_W-1:0] MARK_SOI    = 8'hD8;
    localparam logic [DATA_W-1:0] MARK_EOI    = 8'hD9;
    localparam logic [DATA_W-1:0] MARK_SOS    = 8'hDA;
    localparam logic [DATA_W-1:0] MARK_APP2   = 8'hE2;

    localparam logic [LEN_W-1:0] SIG_LEN   = 16'd11;
    localparam logic [LEN_W-1:0] CHUNK_IDX = 16'd12;
    localparam logic [LEN_W-1:0] TOTAL_IDX = 16'd13;
    localparam logic [LEN_W-1:0] HEAD_LEN  = 16'd14;
    localparam logic [LEN_W-1:0] MIN_LEN   = 16'd2;

    typedef enum logic [3:0] {
        PH_SOI_A,
        PH_SOI_B,
        PH_PREFIX,
        PH_MARKER,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_SKIP,
        PH_ICC_HEAD,
        PH_ICC_DATA,
        PH_DONE,
        PH_FAIL,
        PH_A2_HI,
        PH_A2_LO
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_DATA       = 2'd0,
        KIND_CHUNK_DONE = 2'd1,
        KIND_STATUS     = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_COMPLETE  = 2'd0,
        ST_NO_START  = 2'd1,
        ST_NO_CHUNKS = 2'd2,
        ST_MISSING   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FIN_IDLE,
        FIN_GROUPS,
        FIN_REPORT
    } fin_state_t;

    typedef struct packed {
        kind_t                 kind;
        logic [CHUNK_W-1:0]    seq_num;
        logic [OFFSET_W-1:0]   byte_offset;
        logic [DATA_W-1:0]     profile_byte;
        logic [CHUNK_W-1:0]    seq_total;
        status_t               status;
        logic                  last_of_run;
    } result_t;

    typedef struct packed {
        logic               valid;
        logic [CHUNK_W-1:0] chunk;
        logic [CHUNK_W-1:0] total;
    } chunk_event_t;

    typedef struct packed {
        logic valid;
        logic start_bad;
    } fin_start_t;

    function automatic logic [DATA_W-1:0] icc_sig_byte(input logic [3:0] idx);
        logic [DATA_W-1:0] c;
        c = '0;
        case (idx)
            4'd0:    c = "I";
            4'd1:    c = "C";
            4'd2:    c = "C";
            4'd3:    c = "_";
            4'd4:    c = "P";
            4'd5:    c = "R";
            4'd6:    c = "O";
            4'd7:    c = "F";
            4'd8:    c = "I";
            4'd9:    c = "L";
            4'd10:   c = "E";
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/jicc_result_fifo.sv =====
// small result queue: up to two pushes per cycle, one pop per beat
// depends on jicc_pkg
`default_nettype none

module jicc_result_fifo #(
    parameter int Depth = jicc_pkg::FIFO_DEPTH
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push_a,
    input  wire jicc_pkg::result_t data_a,
    input  wire logic              push_b,
    input  wire jicc_pkg::result_t data_b,
    output logic                   space1,
    output logic                   space2,
    output logic                   out_valid,
    output jicc_pkg::result_t      out_data,
    input  wire logic              out_ready
);
    import jicc_pkg::*;

    localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CNT_W = $clog2(Depth + 1);

    result_t              mem_reg [Depth];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [PTR_W-1:0]     wr_ptr_inc;
    logic                 pop;
    logic [CNT_W-1:0]     push_n;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(Depth - 1)) ? '0 : p + 1'b1;
    endfunction

    assign out_valid  = (count_reg != '0);
    assign out_data   = mem_reg[rd_ptr_reg];
    assign pop        = out_valid && out_ready;
    assign space1     = (count_reg != CNT_W'(Depth));
    assign space2     = (count_reg <= CNT_W'(Depth - 2));
    assign wr_ptr_inc = ptr_inc(wr_ptr_reg);
    assign push_n     = CNT_W'(push_a) + CNT_W'(push_a && push_b);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push_a && push_b) begin
            wr_ptr_next = ptr_inc(wr_ptr_inc);
        end else if (push_a) begin
            wr_ptr_next = wr_ptr_inc;
        end
        if (pop) begin
            rd_ptr_next = ptr_inc(rd_ptr_reg);
        end
        count_next = count_reg + push_n - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_a) begin
            mem_reg[wr_ptr_reg] <= data_a;
        end
        if (push_a && push_b) begin
            mem_reg[wr_ptr_inc] <= data_b;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(Depth))
        else $error("result queue count beyond depth");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_a && push_b) |-> space2)
        else $error("double push without room");

    a_b_needs_a: assert property (@(posedge aclk) disable iff (!aresetn)
        push_b |-> push_a)
        else $error("second slot pushed without first");

endmodule

`default_nettype wire

// ===== rtl/core/jicc_parser.sv =====
// marker segment walker: start marker check, segment lengths, icc header match
// emits data and chunk-complete results; depends on jicc_pkg
`default_nettype none

module jicc_parser (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            in_fire,
    input  wire logic [jicc_pkg::DATA_W-1:0]     data_byte,
    input  wire logic                            end_of_file,
    output logic                                 push_a,
    output jicc_pkg::result_t                    res_a,
    output logic                                 push_b,
    output jicc_pkg::result_t                    res_b,
    output jicc_pkg::chunk_event_t               chunk_evt,
    output jicc_pkg::fin_start_t                 fin_start
);
    import jicc_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [LEN_W-1:0]    seg_rem_reg, seg_rem_next;
    logic [LEN_W-1:0]    pay_idx_reg, pay_idx_next;
    logic [DATA_W-1:0]   len_hi_reg, len_hi_next;
    logic [CHUNK_W-1:0]  cur_chunk_reg, cur_chunk_next;
    logic [CHUNK_W-1:0]  cur_total_reg, cur_total_next;

    logic [LEN_W-1:0]    seg_len;
    logic [LEN_W-1:0]    rem_dec;
    logic [LEN_W-1:0]    idx_inc;
    logic                head_bad;
    logic                data_v;
    logic                done_v;
    result_t             data_res;
    result_t             done_res;

    assign seg_len = {len_hi_reg, data_byte};
    assign rem_dec = seg_rem_reg - 1'b1;
    assign idx_inc = pay_idx_reg + 1'b1;

    always_comb begin
        head_bad = 1'b0;
        if (pay_idx_reg < SIG_LEN && data_byte != icc_sig_byte(pay_idx_reg[3:0])) begin
            head_bad = 1'b1;
        end
        if (pay_idx_reg == TOTAL_IDX && (cur_chunk_reg == '0 || data_byte == '0)) begin
            head_bad = 1'b1;
        end
    end

    always_comb begin
        phase_next     = phase_reg;
        seg_rem_next   = seg_rem_reg;
        pay_idx_next   = pay_idx_reg;
        len_hi_next    = len_hi_reg;
        cur_chunk_next = cur_chunk_reg;
        cur_total_next = cur_total_reg;
        data_v         = 1'b0;
        done_v         = 1'b0;

        unique case (phase_reg)
            PH_SOI_A: begin
                phase_next = (data_byte == MARK_PREFIX) ? PH_SOI_B : PH_FAIL;
            end
            PH_SOI_B: begin
                phase_next = (data_byte == MARK_SOI) ? PH_PREFIX : PH_FAIL;
            end
            PH_PREFIX: begin
                if (data_byte == MARK_PREFIX) begin
                    phase_next = PH_MARKER;
                end
            end
            PH_MARKER: begin
                if (data_byte == MARK_EOI || data_byte == MARK_SOS) begin
                    phase_next = PH_DONE;
                end else if (data_byte == MARK_APP2) begin
                    phase_next = PH_A2_HI;
                end else if (data_byte != MARK_PREFIX) begin
                    phase_next = PH_LEN_HI;
                end
            end
            PH_LEN_HI, PH_A2_HI: begin
                len_hi_next = data_byte;
                phase_next  = (phase_reg == PH_A2_HI) ? PH_A2_LO : PH_LEN_LO;
            end
            PH_LEN_LO, PH_A2_LO: begin
                if (seg_len < MIN_LEN) begin
                    phase_next = PH_DONE;
                end else begin
                    seg_rem_next = seg_len - MIN_LEN;
                    pay_idx_next = '0;
                    if (seg_len == MIN_LEN) begin
                        phase_next = PH_PREFIX;
                    end else begin
                        phase_next = (phase_reg == PH_A2_LO) ? PH_ICC_HEAD : PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                seg_rem_next = rem_dec;
                if (rem_dec == '0) begin
                    phase_next = PH_PREFIX;
                end
            end
            PH_ICC_HEAD: begin
                if (pay_idx_reg == CHUNK_IDX) begin
                    cur_chunk_next = data_byte;
                end
                if (pay_idx_reg == TOTAL_IDX) begin
                    cur_total_next = data_byte;
                end
                pay_idx_next = idx_inc;
                seg_rem_next = rem_dec;
                if (head_bad) begin
                    phase_next = (rem_dec != '0) ? PH_SKIP : PH_PREFIX;
                end else if (pay_idx_reg == TOTAL_IDX) begin
                    phase_next = PH_ICC_DATA;
                    if (rem_dec == '0) begin
                        done_v     = 1'b1;
                        phase_next = PH_PREFIX;
                    end
                end else if (rem_dec == '0) begin
                    phase_next = PH_PREFIX;
                end
            end
            PH_ICC_DATA: begin
                data_v       = 1'b1;
                pay_idx_next = idx_inc;
                seg_rem_next = rem_dec;
                if (rem_dec == '0) begin
                    done_v     = 1'b1;
                    phase_next = PH_PREFIX;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        data_res              = '0;
        data_res.kind         = KIND_DATA;
        data_res.seq_num      = cur_chunk_reg;
        data_res.byte_offset  = pay_idx_reg - HEAD_LEN;
        data_res.profile_byte = data_byte;
        data_res.seq_total    = cur_total_reg;
        data_res.status       = ST_COMPLETE;
        data_res.last_of_run  = !done_v && !end_of_file;

        done_res              = '0;
        done_res.kind         = KIND_CHUNK_DONE;
        done_res.seq_num      = cur_chunk_next;
        done_res.byte_offset  = idx_inc - HEAD_LEN;
        done_res.seq_total    = cur_total_next;
        done_res.status       = ST_COMPLETE;
        done_res.last_of_run  = !end_of_file;
    end

    assign push_a = in_fire && (data_v || done_v);
    assign res_a  = data_v ? data_res : done_res;
    assign push_b = in_fire && data_v && done_v;
    assign res_b  = done_res;

    assign chunk_evt.valid = in_fire && done_v;
    assign chunk_evt.chunk = cur_chunk_next;
    assign chunk_evt.total = cur_total_next;

    assign fin_start.valid     = in_fire && end_of_file;
    assign fin_start.start_bad = (phase_next == PH_SOI_A) || (phase_next == PH_SOI_B)
                              || (phase_next == PH_FAIL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SOI_A;
            seg_rem_reg   <= '0;
            pay_idx_reg   <= '0;
            len_hi_reg    <= '0;
            cur_chunk_reg <= '0;
            cur_total_reg <= '0;
        end else if (in_fire && end_of_file) begin
            phase_reg     <= PH_SOI_A;
            seg_rem_reg   <= '0;
            pay_idx_reg   <= '0;
            len_hi_reg    <= '0;
            cur_chunk_reg <= '0;
            cur_total_reg <= '0;
        end else if (in_fire) begin
            phase_reg     <= phase_next;
            seg_rem_reg   <= seg_rem_next;
            pay_idx_reg   <= pay_idx_next;
            len_hi_reg    <= len_hi_next;
            cur_chunk_reg <= cur_chunk_next;
            cur_total_reg <= cur_total_next;
        end
    end

    a_data_in_chunk: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && phase_reg == PH_ICC_DATA) |-> (cur_chunk_reg != '0 && cur_total_reg != '0))
        else $error("data beat outside a valid chunk");

endmodule

`default_nettype wire

// ===== rtl/core/jicc_chunk_map.sv =====
// seen map of chunk numbers, highest declared total and end-of-file status
// registered group check of chunks 1..total; depends on jicc_pkg
`default_nettype none

module jicc_chunk_map (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire jicc_pkg::chunk_event_t chunk_evt,
    input  wire jicc_pkg::fin_start_t   fin_start,
    input  wire logic                   out_space,
    output logic                        busy,
    output logic                        status_push,
    output jicc_pkg::result_t           status_res
);
    import jicc_pkg::*;

    logic [MAP_DEPTH-1:0]  seen_reg, seen_next;
    logic [CHUNK_W-1:0]    high_total_reg, high_total_next;
    logic                  any_chunk_reg, any_chunk_next;
    logic                  start_bad_reg;
    logic [MAP_GROUPS-1:0] grp_miss_reg, grp_miss_next;
    fin_state_t            fin_state_reg, fin_state_next;
    logic [MAP_DEPTH-1:0]  needed_missing;
    status_t               status_val;

    always_comb begin
        for (int i = 0; i < MAP_DEPTH; i++) begin
            needed_missing[i] = (i != 0) && (CHUNK_W'(i) <= high_total_reg) && !seen_reg[i];
        end
        for (int g = 0; g < MAP_GROUPS; g++) begin
            grp_miss_next[g] = |needed_missing[g*GROUP_SIZE +: GROUP_SIZE];
        end
    end

    always_comb begin
        priority if (start_bad_reg) begin
            status_val = ST_NO_START;
        end else if (!any_chunk_reg) begin
            status_val = ST_NO_CHUNKS;
        end else if (|grp_miss_reg) begin
            status_val = ST_MISSING;
        end else begin
            status_val = ST_COMPLETE;
        end
    end

    always_comb begin
        status_res              = '0;
        status_res.kind         = KIND_STATUS;
        status_res.seq_total    = high_total_reg;
        status_res.status       = status_val;
        status_res.last_of_run  = 1'b1;
    end

    assign busy        = (fin_state_reg != FIN_IDLE);
    assign status_push = (fin_state_reg == FIN_REPORT) && out_space;

    always_comb begin
        fin_state_next  = fin_state_reg;
        seen_next       = seen_reg;
        high_total_next = high_total_reg;
        any_chunk_next  = any_chunk_reg;
        if (chunk_evt.valid) begin
            seen_next[chunk_evt.chunk] = 1'b1;
            any_chunk_next             = 1'b1;
            if (chunk_evt.total > high_total_reg) begin
                high_total_next = chunk_evt.total;
            end
        end
        unique case (fin_state_reg)
            FIN_IDLE: begin
                if (fin_start.valid) begin
                    fin_state_next = FIN_GROUPS;
                end
            end
            FIN_GROUPS: begin
                fin_state_next = FIN_REPORT;
            end
            FIN_REPORT: begin
                if (out_space) begin
                    fin_state_next  = FIN_IDLE;
                    seen_next       = '0;
                    high_total_next = '0;
                    any_chunk_next  = 1'b0;
                end
            end
            default: begin
                fin_state_next = FIN_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_state_reg  <= FIN_IDLE;
            seen_reg       <= '0;
            high_total_reg <= '0;
            any_chunk_reg  <= 1'b0;
            start_bad_reg  <= 1'b0;
        end else begin
            fin_state_reg  <= fin_state_next;
            seen_reg       <= seen_next;
            high_total_reg <= high_total_next;
            any_chunk_reg  <= any_chunk_next;
            if (fin_start.valid) begin
                start_bad_reg <= fin_start.start_bad;
            end
        end
    end

    always_ff @(posedge aclk) begin
        grp_miss_reg <= grp_miss_next;
    end

    a_cleared_after_report: assert property (@(posedge aclk) disable iff (!aresetn)
        status_push |=> (!any_chunk_reg && high_total_reg == '0 && seen_reg == '0))
        else $error("chunk map not cleared after status");

    a_no_event_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> (!chunk_evt.valid && !fin_start.valid))
        else $error("input beat taken during status check");

    a_chunks_imply_total: assert property (@(posedge aclk) disable iff (!aresetn)
        (any_chunk_reg && fin_state_reg == FIN_IDLE) |-> (high_total_reg != '0))
        else $error("chunk recorded with zero highest total");

endmodule

`default_nettype wire

// ===== rtl/core/jpeg_icc_chunk_scanner.sv =====
// timing: a result beat can leave the cycle after its input beat; a chunk-complete
// beat follows the last data beat of its segment, the status beat is pushed after the
// final input beat once a registered check over 16 groups of the seen map is done
// throughput: one input byte per cycle while the queue drains and no status check runs
// reset: aresetn synchronous active low clears state, seen map and result queue
`default_nettype none

module jpeg_icc_chunk_scanner #(
    parameter int FifoDepth = jicc_pkg::FIFO_DEPTH
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [jicc_pkg::DATA_W-1:0]  s_axis_tdata,  // data_byte
    input  wire logic                         s_axis_tlast,  // end_of_file
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // seq_num, byte_offset, profile_byte, seq_total, status, zero pad
    output logic [jicc_pkg::TDATA_W-1:0]      m_axis_tdata,
    output logic [jicc_pkg::KIND_W-1:0]       m_axis_tuser,  // kind
    output logic                              m_axis_tlast   // last_of_run
);
    import jicc_pkg::*;

    logic         in_fire;
    logic         space1;
    logic         space2;
    logic         map_busy;
    logic         par_push_a;
    logic         par_push_b;
    result_t      par_res_a;
    result_t      par_res_b;
    chunk_event_t chunk_evt;
    fin_start_t   fin_start;
    logic         status_push;
    result_t      status_res;
    logic         q_push_a;
    result_t      q_data_a;
    result_t      q_out;

    assign s_axis_tready = !map_busy && space2;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    jicc_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (in_fire),
        .data_byte   (s_axis_tdata),
        .end_of_file (s_axis_tlast),
        .push_a      (par_push_a),
        .res_a       (par_res_a),
        .push_b      (par_push_b),
        .res_b       (par_res_b),
        .chunk_evt   (chunk_evt),
        .fin_start   (fin_start)
    );

    jicc_chunk_map u_chunk_map (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .chunk_evt   (chunk_evt),
        .fin_start   (fin_start),
        .out_space   (space1),
        .busy        (map_busy),
        .status_push (status_push),
        .status_res  (status_res)
    );

    assign q_push_a = par_push_a || status_push;
    assign q_data_a = status_push ? status_res : par_res_a;

    jicc_result_fifo #(
        .Depth (FifoDepth)
    ) u_result_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_a    (q_push_a),
        .data_a    (q_data_a),
        .push_b    (par_push_b),
        .data_b    (par_res_b),
        .space1    (space1),
        .space2    (space2),
        .out_valid (m_axis_tvalid),
        .out_data  (q_out),
        .out_ready (m_axis_tready)
    );

    assign m_axis_tdata = {{TDATA_PAD{1'b0}}, q_out.status, q_out.seq_total,
                           q_out.profile_byte, q_out.byte_offset, q_out.seq_num};
    assign m_axis_tuser = q_out.kind;
    assign m_axis_tlast = q_out.last_of_run;

    a_status_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        status_push |-> !par_push_a)
        else $error("status beat collides with parser beat");

    a_eof_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_axis_tlast) |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("input taken during status check");

    a_room_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |-> space2)
        else $error("input beat accepted without queue room");

endmodule

`default_nettype wire
